### rtl/core/iidl_pkg.sv
// ----------------------------------------------------------------------------
// iidl_pkg: shared definitions for the indexed insert/delete list
// Sizes, action and error codes, the cell command type and word conversions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iidl_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  // Fixed field widths of the channels.
  localparam int ACT_W   = 3;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 7;
  localparam int ERR_W   = 2;

  // Derived internal widths.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int EXT_W = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;

  localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_APPEND = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_INDEX = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd3;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic                  shift_up;
    logic                  shift_dn;
    logic [IDX_W-1:0]      pos;
    logic [DATA_WIDTH-1:0] wdata;
  } cell_cmd_t;

  function automatic logic [DATA_WIDTH-1:0] to_word(input logic signed [VAL_W-1:0] v);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] from_word(input logic [DATA_WIDTH-1:0] w);
    logic signed [DATA_WIDTH-1:0] s;
    logic signed [EXT_W-1:0]      e;
    s = signed'(w);
    e = EXT_W'(s);
    return e[VAL_W-1:0];
  endfunction

endpackage

### rtl/core/iidl_if.sv
// ----------------------------------------------------------------------------
// iidl_if: channel interfaces of the indexed insert/delete list
// Valid/ready channels for the action requests and for the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface iidl_in_if;
  import iidl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [POS_W-1:0]         position;
  logic signed [VAL_W-1:0]  item_value;

  modport source (output valid, output action, output position, output item_value,
                  input ready);
  modport sink   (input valid, input action, input position, input item_value,
                  output ready);
endinterface

interface iidl_out_if;
  import iidl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  read_value;
  logic [COUNT_W-1:0]       count;
  logic [ERR_W-1:0]         error;

  modport source (output valid, output read_value, output count, output error,
                  input ready);
  modport sink   (input valid, input read_value, input count, input error,
                  output ready);
endinterface

### rtl/core/iidl_cell.sv
// ----------------------------------------------------------------------------
// iidl_cell: one storage cell of the list
// Holds one entry and takes its left or right neighbour's word, or the new word, on a shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iidl_cell
  import iidl_pkg::*;
(
  input  logic                  clk,
  input  logic [IDX_W-1:0]      my_idx,
  input  cell_cmd_t             cmd,
  input  logic [DATA_WIDTH-1:0] left_in,
  input  logic [DATA_WIDTH-1:0] right_in,
  output logic [DATA_WIDTH-1:0] data_q
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.shift_up) begin
      if (my_idx > cmd.pos) begin
        data_nxt = left_in;
      end else if (my_idx == cmd.pos) begin
        data_nxt = cmd.wdata;
      end
    end else if (cmd.shift_dn) begin
      if (my_idx >= cmd.pos) begin
        data_nxt = right_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

### rtl/core/iidl_row.sv
// ----------------------------------------------------------------------------
// iidl_row: the chain of list cells
// Links the cells to their neighbours and selects the entry to be read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iidl_row
  import iidl_pkg::*;
(
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [IDX_W-1:0]      rd_idx,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = cell_q[i-1];
    end

    // The top cell's right neighbour is itself; its content past the end is unused.
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_q[i];
    end else begin : g_inner_r
      assign right_w = cell_q[i+1];
    end

    iidl_cell u_cell (
      .clk      (clk),
      .my_idx   (IDX_W'(i)),
      .cmd      (cmd),
      .left_in  (left_w),
      .right_in (right_w),
      .data_q   (cell_q[i])
    );
  end

  assign rd_data = cell_q[rd_idx];

endmodule

### rtl/core/indexed_insert_delete_list.sv
// ----------------------------------------------------------------------------
// indexed_insert_delete_list: fixed-capacity ordered list of signed words
// The list is a row of CAPACITY cells, each holding one entry. Every
// transaction on the input channel carries one action: read the entry at a
// position, insert a value at a position (later entries move up one place),
// append at the end, delete at a position (later entries move down one
// place) or pop the last entry. All cells move together in the cycle in
// which the transaction is taken, whatever its position, and a new
// transaction is taken in each cycle for as long as the result register is
// empty or being emptied. Each action gives exactly one result transaction
// with the read value (zero unless a read succeeded), the entry count after
// the action and an error code. A refused action (index out of range, list
// full, list empty) changes nothing; action codes five to seven are ignored
// and report success. Cells hold no valid state and are not cleared at
// reset; only entries below the count are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_insert_delete_list
  import iidl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  iidl_in_if.sink    in_ch,
  iidl_out_if.source out_ch
);

  // Control state: number of entries held and the result register flag.
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;

  // Result payload registers.
  logic [VAL_W-1:0]   out_value_r;
  logic [VAL_W-1:0]   out_value_nxt;
  logic [COUNT_W-1:0] out_count_r;
  logic [ERR_W-1:0]   out_err_r;
  logic [ERR_W-1:0]   err_nxt;

  logic                  accept;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic                  is_full;
  cell_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] rd_data;

  // A transaction is taken whenever the result register is free or being
  // emptied in the same cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign pos_ext = CMP_W'(in_ch.position);
  assign cnt_ext = CMP_W'(count_r);
  assign is_full = (count_r == CNT_W'(CAPACITY));

  // Decode the action against the current count and build the cell command.
  always_comb begin
    count_nxt     = count_r;
    err_nxt       = ERR_OK;
    out_value_nxt = '0;
    cmd.shift_up  = 1'b0;
    cmd.shift_dn  = 1'b0;
    cmd.pos       = IDX_W'(in_ch.position);
    cmd.wdata     = to_word(in_ch.item_value);

    case (in_ch.action)
      ACT_READ: begin
        if (pos_ext >= cnt_ext) begin
          err_nxt = ERR_INDEX;
        end else begin
          out_value_nxt = from_word(rd_data);
        end
      end
      ACT_INSERT: begin
        // The index test is made before the full test.
        if (pos_ext > cnt_ext) begin
          err_nxt = ERR_INDEX;
        end else if (is_full) begin
          err_nxt = ERR_FULL;
        end else begin
          cmd.shift_up = accept;
          count_nxt    = count_r + CNT_W'(1);
        end
      end
      ACT_APPEND: begin
        if (is_full) begin
          err_nxt = ERR_FULL;
        end else begin
          // An append is an insert at the current end of the list.
          cmd.shift_up = accept;
          cmd.pos      = IDX_W'(count_r);
          count_nxt    = count_r + CNT_W'(1);
        end
      end
      ACT_DELETE: begin
        if (pos_ext >= cnt_ext) begin
          err_nxt = ERR_INDEX;
        end else begin
          cmd.shift_dn = accept;
          count_nxt    = count_r - CNT_W'(1);
        end
      end
      ACT_POP: begin
        // The last entry simply falls outside the count.
        if (count_r == '0) begin
          err_nxt = ERR_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r <= out_value_nxt;
      out_count_r <= COUNT_W'(count_nxt);
      out_err_r   <= err_nxt;
    end
  end

  iidl_row u_row (
    .clk     (clk),
    .cmd     (cmd),
    .rd_idx  (IDX_W'(in_ch.position)),
    .rd_data (rd_data)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = signed'(out_value_r);
  assign out_ch.count      = out_count_r;
  assign out_ch.error      = out_err_r;

  // The count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // Every accepted transaction leaves a result waiting in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transaction produced no result");

  // A full error is only reported when the list holds every entry.
  a_full_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r == ERR_FULL) |-> (out_count_r == COUNT_W'(CAPACITY)))
    else $error("full error reported on a list that is not full");

  // A read value is non-zero only for a successful read.
  a_value_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r != ERR_OK) |-> (out_value_r == '0))
    else $error("read value given with a refused action");

endmodule
